/* design/prk_pkg.sv */
// Shared constants, types and the factorial function for the permutation rank block.
`timescale 1ns / 1ps
`default_nettype none

package prk_pkg;

   localparam int unsigned MAX_LEN_DEF = 16;
   localparam int unsigned ELEM_W      = 4;
   localparam int unsigned PLEN_W      = 5;
   localparam int unsigned RANK_W      = 45;
   localparam logic [PLEN_W-1:0] PLEN_RESET = 5'd16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store;      // an item is accepted this cycle
      logic scan_step;  // form one weighted count product
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic final_elem; // the element held at the input completes the permutation
      logic scan_last;  // the scan index points at the last position
   } status_type;

   // k factorial in 64 bits; only ever evaluated at elaboration.
   function automatic logic [63:0] factorial_f(input int unsigned k);
      logic [63:0] f;
      f = 64'd1;
      for (int unsigned j = 2; j <= 20; j++) begin
         if (j <= k) begin
            f = f * 64'(j);
         end
      end
      return f;
   endfunction

endpackage

`default_nettype wire

/* design/prk_ctrl.sv */
// Controller state machine for the permutation rank block.
`timescale 1ns / 1ps
`default_nettype none

module prk_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   output logic                     rsp_valid,
   output prk_pkg::cmd_type         cmd,
   input  wire prk_pkg::status_type st
);
   import prk_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy      = (state_ff == S_SCAN) || (state_ff == S_DRAIN);
   assign accept    = start && !busy;
   assign rsp_valid = (state_ff == S_EMIT);

   always_comb begin
      cmd.store     = accept;
      cmd.scan_step = (state_ff == S_SCAN);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE, S_EMIT: begin
            if (accept && st.final_elem) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (st.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_EMIT;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_after_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DRAIN))
      else $error("result strobe without a completed accumulation");

   a_final_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && st.final_elem) |=> (state_ff == S_SCAN))
      else $error("final element did not start the scan");

endmodule

`default_nettype wire

/* design/prk_dp.sv */
// Datapath for the permutation rank block: element cells, counts and the weighted sum.
`timescale 1ns / 1ps
`default_nettype none

module prk_dp #(
   parameter int unsigned MAX_LEN = prk_pkg::MAX_LEN_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [prk_pkg::PLEN_W-1:0]  csr_wdata,
   input  wire logic [prk_pkg::ELEM_W-1:0]  element,
   input  wire prk_pkg::cmd_type            cmd,
   output prk_pkg::status_type              st,
   output logic [prk_pkg::RANK_W-1:0]       rank
);
   import prk_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_LEN);
   localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
   localparam int unsigned CNT_W = $clog2(MAX_LEN);

   logic [PLEN_W-1:0] plen_ff;
   logic [LEN_W-1:0]  len_eff;
   logic [IDX_W-1:0]  pos_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [LEN_W-1:0]  weight;
   logic [ELEM_W-1:0] elem_ff [MAX_LEN];
   logic [CNT_W-1:0]  cnt_ff  [MAX_LEN];
   logic [RANK_W-1:0] fact_tab [MAX_LEN];
   logic [RANK_W-1:0] prod_ff;
   logic              prod_vld_ff;
   logic [RANK_W-1:0] acc_ff;
   logic              final_store;

   for (genvar k = 0; k < MAX_LEN; k++) begin : g_fact
      assign fact_tab[k] = RANK_W'(factorial_f(k));
   end

   always_comb begin
      if (plen_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (plen_ff > PLEN_W'(MAX_LEN)) begin
         len_eff = LEN_W'(MAX_LEN);
      end else begin
         len_eff = plen_ff[LEN_W-1:0];
      end
   end

   assign st.final_elem = (LEN_W'(pos_ff) + LEN_W'(1)) == len_eff;
   assign st.scan_last  = (LEN_W'(idx_ff) + LEN_W'(1)) == len_eff;
   assign final_store   = cmd.store && st.final_elem;
   assign weight        = len_eff - LEN_W'(1) - LEN_W'(idx_ff);
   assign rank          = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= PLEN_RESET;
         pos_ff  <= '0;
      end else if (csr_we) begin
         plen_ff <= csr_wdata;
         pos_ff  <= '0;
      end else if (cmd.store) begin
         pos_ff <= final_store ? '0 : pos_ff + IDX_W'(1);
      end
   end

   // Each cell compares the broadcast element with its own stored value.
   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      always_ff @(posedge clock) begin
         if (cmd.store) begin
            if (pos_ff == IDX_W'(i)) begin
               elem_ff[i] <= element;
               cnt_ff[i]  <= '0;
            end else if ((IDX_W'(i) < pos_ff) && (element < elem_ff[i])) begin
               cnt_ff[i] <= cnt_ff[i] + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= cmd.scan_step;
         if (final_store) begin
            idx_ff <= '0;
            acc_ff <= '0;
         end else begin
            if (cmd.scan_step) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
            if (prod_vld_ff) begin
               acc_ff <= acc_ff + prod_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         prod_ff <= RANK_W'(cnt_ff[idx_ff] * fact_tab[weight[IDX_W-1:0]]);
      end
   end

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> (LEN_W'(idx_ff) < len_eff))
      else $error("scan index beyond the permutation length");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (final_store && !csr_we) |=> (pos_ff == '0) && (idx_ff == '0) && (acc_ff == '0))
      else $error("position, scan index or sum not cleared after the final element");

endmodule

`default_nettype wire

/* design/permutation_rank.sv */
// Top level of the permutation rank block: controller and datapath joined.
`timescale 1ns / 1ps
`default_nettype none

// The block ranks a permutation in lexicographic order through its Lehmer code. One element
// is taken per item while start is high and busy is low, in order of position; an element
// that does not complete the permutation is absorbed without raising busy, so such items
// may arrive back to back. The item that completes a permutation of length L raises busy
// while one shared multiplier steps through the stored counts, one position per cycle, and
// the weighted sum then drains; the rank appears on rsp_rank with rsp_valid high for
// exactly one cycle after that. The receiver cannot stall the result and must take it in
// that cycle, although the next element may already be accepted in the same cycle as the
// strobe. The length register is written through csr_we and csr_wdata; the user must
// write it only while the block is idle, and the block itself does not enforce this. A
// value of zero acts as one, a value above MAX_LEN acts as MAX_LEN, and any write abandons
// a permutation that has only been partly entered. Repeated or out-of-range element values
// are not checked. After reset the length is sixteen and no clearing pass is needed.

module permutation_rank #(
   parameter int unsigned MAX_LEN = prk_pkg::MAX_LEN_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [prk_pkg::ELEM_W-1:0]  req_element,
   output logic                             rsp_valid,
   output logic [prk_pkg::RANK_W-1:0]       rsp_rank,
   input  wire logic                        csr_we,
   input  wire logic [prk_pkg::PLEN_W-1:0]  csr_wdata
);
   import prk_pkg::*;

   cmd_type    cmd;
   status_type st;

   // The controller sequences accepting items, the product scan and the result strobe.
   prk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .st        (st)
   );

   // The datapath holds the element cells, their counts, the length register and the sum.
   prk_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .element   (req_element),
      .cmd       (cmd),
      .st        (st),
      .rank      (rsp_rank)
   );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the permutation rank block, with its rank scoreboard.
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the Lehmer code state and queues the ranks it expects.
class perm_rank_board;
   localparam int unsigned DEPTH = prk_pkg::MAX_LEN_DEF;

   logic [prk_pkg::RANK_W-1:0] ranks_due[$];
   logic [prk_pkg::RANK_W-1:0] fact[DEPTH];
   logic [prk_pkg::ELEM_W-1:0] seen[DEPTH];
   logic [4:0]                 later_smaller[DEPTH];
   int unsigned                filled;
   logic [prk_pkg::PLEN_W-1:0] length_reg;
   int                         mismatches;

   function new();
      fact[0] = 1;
      for (int k = 1; k < DEPTH; k++) begin
         fact[k] = fact[k-1] * k;
      end
      for (int k = 0; k < DEPTH; k++) begin
         seen[k] = '0;
      end
      length_reg = prk_pkg::PLEN_RESET;
      mismatches = 0;
      clear();
   endfunction

   function void clear();
      for (int k = 0; k < DEPTH; k++) begin
         later_smaller[k] = '0;
      end
      filled = 0;
   endfunction

   function int unsigned active_length();
      if (length_reg == 0) begin
         return 1;
      end
      if (length_reg > DEPTH) begin
         return DEPTH;
      end
      return length_reg;
   endfunction

   function int unsigned pending();
      return ranks_due.size();
   endfunction

   // A length write abandons any partly entered permutation.
   function void set_length(logic [prk_pkg::PLEN_W-1:0] value);
      length_reg = value;
      clear();
   endfunction

   function void note_element(logic [prk_pkg::ELEM_W-1:0] value);
      int unsigned len;
      logic [63:0] sum;
      len = active_length();
      if (filled >= len) begin
         clear();
      end
      for (int k = 0; k < filled; k++) begin
         if (value < seen[k]) begin
            later_smaller[k] = later_smaller[k] + 1;
         end
      end
      seen[filled] = value;
      later_smaller[filled] = '0;
      filled++;
      if (filled == len) begin
         sum = 0;
         for (int k = 0; k < len; k++) begin
            sum = sum + 64'(later_smaller[k]) * 64'(fact[len-1-k]);
         end
         ranks_due.push_back(sum[prk_pkg::RANK_W-1:0]);
         clear();
      end
   endfunction

   function void check_rank(logic [prk_pkg::RANK_W-1:0] got);
      logic [prk_pkg::RANK_W-1:0] want;
      if (ranks_due.size() == 0) begin
         $error("rank: expected no result, actual %0d", got);
         mismatches++;
         return;
      end
      want = ranks_due.pop_front();
      if (got !== want) begin
         $error("rank: expected %0d, actual %0d", want, got);
         mismatches++;
      end
   endfunction
endclass

module testbench;
   import prk_pkg::*;

   // Length codes used by name in the directed and random parts.
   localparam logic [PLEN_W-1:0] LEN_ZERO = 5'd0;
   localparam logic [PLEN_W-1:0] LEN_ONE  = 5'd1;
   localparam logic [PLEN_W-1:0] LEN_FULL = 5'd16;
   localparam logic [PLEN_W-1:0] LEN_TOP  = 5'd31;
   localparam logic [PLEN_W-1:0] LEN_THREE = 5'd3;

   // These quiet cycles outlast the busy stretch of a completing item of the longest
   // permutation, so they are ample before a length write or at the very end.
   localparam int SETTLE_CYCLES = 24;
   localparam int ITEM_TARGET   = 700;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [ELEM_W-1:0]   req_element;
   logic                rsp_valid;
   logic [RANK_W-1:0]   rsp_rank;
   logic                csr_we;
   logic [PLEN_W-1:0]   csr_wdata;

   perm_rank_board board;
   int             sent;

   permutation_rank i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_element (req_element),
      .rsp_valid   (rsp_valid),
      .rsp_rank    (rsp_rank),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // The result cannot be held off, so every strobe is checked on the edge that ends it.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         board.check_rank(rsp_rank);
      end
   end

   // Offers one item and returns once the block has taken it. Random idle cycles come first,
   // except over a stretch in the middle of the run where items are offered back to back.
   // Start is left high afterwards so that the next item can follow without a gap.
   task automatic feed_element(input logic [ELEM_W-1:0] value);
      while (!(sent >= 250 && sent < 400) && $urandom_range(0, 99) < 36) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start       <= 1'b1;
      req_element <= value;
      do begin
         @(posedge clock);
      end while (busy);
      board.note_element(value);
      sent++;
   endtask

   // Stops offering items and waits until every expected rank has been seen, then lets the
   // block finish any work that produces no result.
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the length register; the block must already be idle.
   task automatic write_length(input logic [PLEN_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      board.set_length(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Feeds one permutation of the current length. Well-formed ones use distinct values
   // drawn from a shuffle; the others use free values, so repeats appear. A partial one
   // stops short and is abandoned by the next length write.
   task automatic feed_permutation(input bit distinct, input bit partial);
      int unsigned len;
      int unsigned count;
      int          pool[16];
      int          j;
      int          tmp;
      len = board.active_length();
      for (int k = 0; k < 16; k++) begin
         pool[k] = k;
      end
      for (int k = 15; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = pool[k];
         pool[k] = pool[j];
         pool[j] = tmp;
      end
      count = len;
      if (partial) begin
         count = $urandom_range(1, len - 1);
      end
      for (int k = 0; k < count; k++) begin
         if (distinct) begin
            feed_element(ELEM_W'(pool[k]));
         end else begin
            feed_element(ELEM_W'($urandom_range(0, 15)));
         end
      end
   endtask

   initial begin
      logic [PLEN_W-1:0] len_code;
      int unsigned       perms;
      int unsigned       pick;
      clock       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_element = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      sent        = 0;
      board       = new();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The reset length of sixteen with a fully descending permutation gives
      // the largest rank of all, and uses both extreme element values.
      for (int k = 15; k >= 0; k--) begin
         feed_element(ELEM_W'(k));
      end
      drain();
      // A length of zero behaves as a length of one: every item is ranked zero on its own.
      write_length(LEN_ZERO);
      feed_element(4'd15);
      drain();
      // Equal elements must not count as smaller than one another.
      write_length(LEN_THREE);
      feed_element(4'd7);
      feed_element(4'd7);
      feed_element(4'd2);
      drain();
      // Two elements of a new permutation, then a write of the largest length code that
      // abandons them.
      feed_element(4'd9);
      feed_element(4'd4);
      drain();
      write_length(LEN_TOP);

      // Random part: phases of a few permutations, each under a fresh length. Most lengths are
      // random codes, with the extremes drawn on purpose now and then.
      while (sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin
               len_code = LEN_ZERO;
            end
            1: begin
               len_code = LEN_ONE;
            end
            2: begin
               len_code = LEN_FULL;
            end
            3: begin
               len_code = LEN_TOP;
            end
            default: begin
               len_code = PLEN_W'($urandom_range(0, 31));
            end
         endcase
         write_length(len_code);
         perms = $urandom_range(1, 6);
         for (int p = 0; p < perms; p++) begin
            pick = $urandom_range(0, 9);
            if (p == perms - 1 && pick == 9 && board.active_length() > 1) begin
               feed_permutation(1'b1, 1'b1);
            end else begin
               feed_permutation(pick < 7, 1'b0);
            end
         end
         drain();
      end

      drain();
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Guards against a hang: far longer than the slowest correct run could take.
   initial begin
      #3000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* permutation_rank.f */
design/prk_pkg.sv
design/prk_ctrl.sv
design/prk_dp.sv
design/permutation_rank.sv
tb/testbench.sv
